### sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// Serial line editor package
// Shared constants, command codes, state codes and the command record that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package sle_pkg;

    // Default line store depth; one entry is always left unused.
    localparam int LINE_CAPACITY_DEF = 16;

    // Depth of the command queue between front end and back end.
    localparam int QUEUE_DEPTH = 2;

    // Result kinds.
    localparam logic [2:0] KIND_ECHO = 3'd0;
    localparam logic [2:0] KIND_LINE = 3'd1;
    localparam logic [2:0] KIND_BELL = 3'd2;
    localparam logic [2:0] KIND_EOF  = 3'd3;
    localparam logic [2:0] KIND_ERR  = 3'd4;
    localparam logic [2:0] KIND_INTR = 3'd5;

    // Character codes.
    localparam logic [7:0] CTRL_MASK   = 8'h1F;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_SP       = 8'h20;
    localparam logic [7:0] CH_TILDE    = 8'h7E;
    localparam logic [7:0] CH_DEL      = 8'h7F;
    localparam logic [7:0] CH_HIGH_LO  = 8'hA0;
    localparam logic [7:0] CH_CTRL_C   = 8'h63 & CTRL_MASK;
    localparam logic [7:0] CH_CTRL_R   = 8'h72 & CTRL_MASK;
    localparam logic [7:0] CH_CTRL_U   = 8'h75 & CTRL_MASK;
    localparam logic [7:0] CH_CTRL_W   = 8'h77 & CTRL_MASK;

    // Commands produced by the classifier.
    typedef enum logic [3:0] {
        CMD_IGNORE,
        CMD_EOF,
        CMD_ERR,
        CMD_INTR,
        CMD_NEWLINE,
        CMD_PRINT,
        CMD_ERASE,
        CMD_REPRINT,
        CMD_KILL_LINE,
        CMD_KILL_WORD
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data;
    } t_cmd_item;

    // How far an erase sequence runs.
    typedef enum logic [1:0] {
        ER_SINGLE,
        ER_LINE,
        ER_WORD
    } t_erase_mode;

    // Back end sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NL_LF,
        ST_WALK_RD,
        ST_WALK_TX,
        ST_NL_END,
        ST_KW_CHECK,
        ST_ER_BS1,
        ST_ER_SP,
        ST_ER_WAIT,
        ST_ER_BS2
    } t_state;

endpackage

### sv/sle_if.sv
// ----------------------------------------------------------------------------
// Serial line editor channels
// Valid/ready channels for received bytes and for editor results.
// ----------------------------------------------------------------------------
interface sle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       framing_error;
    logic       overrun_error;

    modport source (output valid, output rx_byte, output framing_error,
                    output overrun_error, input ready);
    modport sink   (input valid, input rx_byte, input framing_error,
                    input overrun_error, output ready);
endinterface

interface sle_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input last,
                    output ready);
endinterface

### sv/sle_front.sv
// ----------------------------------------------------------------------------
// Serial line editor front end
// Accepts received bytes and turns each into an editing command.
// ----------------------------------------------------------------------------
module sle_front (
    sle_in_if.sink              i_in,
    input  logic                i_q_full,
    output logic                o_push,
    output sle_pkg::t_cmd_item  o_item
);
    import sle_pkg::*;

    logic [7:0] w_lf;
    logic [7:0] w_char;
    logic       w_printable;
    t_cmd       w_cmd;

    // CR acts as LF, tab is stored as a space.
    assign w_lf        = (i_in.rx_byte == CH_CR) ? CH_LF : i_in.rx_byte;
    assign w_char      = (w_lf == CH_TAB) ? CH_SP : w_lf;
    assign w_printable = ((w_char >= CH_SP) && (w_char <= CH_TILDE)) ||
                         (w_char >= CH_HIGH_LO);

    always_comb begin
        priority if (i_in.framing_error) begin
            w_cmd = CMD_EOF;
        end else if (i_in.overrun_error) begin
            w_cmd = CMD_ERR;
        end else if (w_char == CH_LF) begin
            w_cmd = CMD_NEWLINE;
        end else if (w_printable) begin
            w_cmd = CMD_PRINT;
        end else if (w_char == CH_CTRL_C) begin
            w_cmd = CMD_INTR;
        end else if ((w_char == CH_BS) || (w_char == CH_DEL)) begin
            w_cmd = CMD_ERASE;
        end else if (w_char == CH_CTRL_R) begin
            w_cmd = CMD_REPRINT;
        end else if (w_char == CH_CTRL_U) begin
            w_cmd = CMD_KILL_LINE;
        end else if (w_char == CH_CTRL_W) begin
            w_cmd = CMD_KILL_WORD;
        end else begin
            w_cmd = CMD_IGNORE;
        end
    end

    // Ignored bytes are taken and dropped here; they never reach the queue.
    assign i_in.ready  = !i_q_full;
    assign o_push      = i_in.valid && !i_q_full && (w_cmd != CMD_IGNORE);
    assign o_item.cmd  = w_cmd;
    assign o_item.data = w_char;

endmodule

### sv/sle_queue.sv
// ----------------------------------------------------------------------------
// Serial line editor command queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module sle_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sle_pkg::t_cmd_item  i_item,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output sle_pkg::t_cmd_item  o_item
);
    import sle_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] PTR_LAST  = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] COUNT_MAX = QCW'(QUEUE_DEPTH);

    t_cmd_item      r_buf [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_count == COUNT_MAX);
    assign o_valid = (r_count != '0);
    assign o_item  = r_buf[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/sle_back.sv
// ----------------------------------------------------------------------------
// Serial line editor back end
// Keeps the line store and fill count and plays out the results of each
// command through a registered output stage.
// ----------------------------------------------------------------------------
module sle_back #(
    parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  sle_pkg::t_cmd_item  i_q_item,
    output logic                o_q_pop,
    sle_out_if.source           o_out
);
    import sle_pkg::*;

    localparam int FW = $clog2(LINE_CAPACITY);
    localparam logic [FW-1:0] FILL_MAX = FW'(LINE_CAPACITY - 1);

    logic [7:0]    r_mem [LINE_CAPACITY];
    logic [7:0]    r_rd_data;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [FW-1:0] r_idx;
    logic [FW-1:0] n_idx;
    t_erase_mode   r_mode;
    t_erase_mode   n_mode;
    logic          r_nl;
    logic          n_nl;
    t_state        r_state;
    t_state        n_state;

    logic          r_out_valid;
    logic [2:0]    r_out_kind;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic          w_ld;
    logic          w_emit;
    logic [2:0]    w_kind;
    logic [7:0]    w_byte;
    logic          w_last;
    logic          w_we;
    logic [FW-1:0] w_rd_addr;
    logic          w_at_end;
    logic          w_more;

    // The output register can take a new result when empty or being drained.
    assign w_ld      = !r_out_valid || o_out.ready;
    assign w_at_end  = (r_idx == r_fill - 1'b1);
    assign w_rd_addr = ((r_state == ST_WALK_RD) || (r_state == ST_WALK_TX)) ?
                       r_idx : r_fill - 1'b1;
    // After one erase, decide whether another follows.
    assign w_more    = (r_mode != ER_SINGLE) && (r_fill != '0) &&
                       ((r_mode == ER_LINE) || (r_rd_data != CH_SP));

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_fill] <= i_q_item.data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && w_ld) begin
                    unique case (i_q_item.cmd)
                        CMD_NEWLINE:   n_state = ST_NL_LF;
                        CMD_REPRINT:   n_state = (r_fill != '0) ? ST_WALK_RD : ST_IDLE;
                        CMD_ERASE,
                        CMD_KILL_LINE: n_state = (r_fill != '0) ? ST_ER_BS1 : ST_IDLE;
                        CMD_KILL_WORD: n_state = (r_fill != '0) ? ST_KW_CHECK : ST_IDLE;
                        CMD_IGNORE, CMD_EOF, CMD_ERR, CMD_INTR,
                        CMD_PRINT:     n_state = ST_IDLE;
                    endcase
                end
            end
            ST_NL_LF: begin
                if (w_ld) begin
                    n_state = (r_fill == '0) ? ST_NL_END : ST_WALK_RD;
                end
            end
            ST_WALK_RD:  n_state = ST_WALK_TX;
            ST_WALK_TX: begin
                if (w_ld) begin
                    if (w_at_end) begin
                        n_state = r_nl ? ST_NL_END : ST_IDLE;
                    end else begin
                        n_state = ST_WALK_RD;
                    end
                end
            end
            ST_NL_END: begin
                if (w_ld) begin
                    n_state = ST_IDLE;
                end
            end
            ST_KW_CHECK: n_state = (r_rd_data == CH_SP) ? ST_IDLE : ST_ER_BS1;
            ST_ER_BS1: begin
                if (w_ld) begin
                    n_state = ST_ER_SP;
                end
            end
            ST_ER_SP: begin
                if (w_ld) begin
                    n_state = ST_ER_WAIT;
                end
            end
            ST_ER_WAIT:  n_state = ST_ER_BS2;
            ST_ER_BS2: begin
                if (w_ld) begin
                    n_state = w_more ? ST_ER_BS1 : ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb begin
        w_emit  = 1'b0;
        w_kind  = KIND_ECHO;
        w_byte  = '0;
        w_last  = 1'b0;
        w_we    = 1'b0;
        o_q_pop = 1'b0;
        n_fill  = r_fill;
        n_idx   = r_idx;
        n_mode  = r_mode;
        n_nl    = r_nl;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid && w_ld) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_item.cmd)
                        CMD_EOF: begin
                            w_emit = 1'b1;
                            w_kind = KIND_EOF;
                            w_last = 1'b1;
                            n_fill = '0;
                        end
                        CMD_ERR: begin
                            w_emit = 1'b1;
                            w_kind = KIND_ERR;
                            w_last = 1'b1;
                            n_fill = '0;
                        end
                        CMD_INTR: begin
                            w_emit = 1'b1;
                            w_kind = KIND_INTR;
                            w_last = 1'b1;
                            n_fill = '0;
                        end
                        CMD_PRINT: begin
                            w_emit = 1'b1;
                            w_last = 1'b1;
                            if (r_fill == FILL_MAX) begin
                                w_kind = KIND_BELL;
                            end else begin
                                w_we   = 1'b1;
                                w_byte = i_q_item.data;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        CMD_NEWLINE: begin
                            w_emit = 1'b1;
                            w_byte = CH_CR;
                            n_nl   = 1'b1;
                        end
                        CMD_REPRINT: begin
                            w_emit = 1'b1;
                            w_byte = CH_CR;
                            w_last = (r_fill == '0);
                            n_nl   = 1'b0;
                            n_idx  = '0;
                        end
                        CMD_ERASE:     n_mode = ER_SINGLE;
                        CMD_KILL_LINE: n_mode = ER_LINE;
                        CMD_KILL_WORD: n_mode = ER_WORD;
                        CMD_IGNORE:    n_mode = r_mode;
                    endcase
                end
            end
            ST_NL_LF: begin
                if (w_ld) begin
                    w_emit = 1'b1;
                    w_byte = CH_LF;
                    n_idx  = '0;
                end
            end
            ST_WALK_TX: begin
                if (w_ld) begin
                    w_emit = 1'b1;
                    w_kind = r_nl ? KIND_LINE : KIND_ECHO;
                    w_byte = r_rd_data;
                    w_last = !r_nl && w_at_end;
                    if (!w_at_end) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            ST_NL_END: begin
                if (w_ld) begin
                    w_emit = 1'b1;
                    w_kind = KIND_LINE;
                    w_byte = CH_LF;
                    w_last = 1'b1;
                    n_fill = '0;
                end
            end
            ST_ER_BS1: begin
                if (w_ld) begin
                    w_emit = 1'b1;
                    w_byte = CH_BS;
                end
            end
            ST_ER_SP: begin
                if (w_ld) begin
                    w_emit = 1'b1;
                    w_byte = CH_SP;
                    n_fill = r_fill - 1'b1;
                end
            end
            ST_ER_BS2: begin
                if (w_ld) begin
                    w_emit = 1'b1;
                    w_byte = CH_BS;
                    w_last = !w_more;
                end
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_idx       <= '0;
            r_mode      <= ER_SINGLE;
            r_nl        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_mode  <= n_mode;
            r_nl    <= n_nl;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_kind <= w_kind;
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.kind     = r_out_kind;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

endmodule

### sv/serial_line_editor.sv
// ----------------------------------------------------------------------------
// Serial line editor
// Canonical-mode line editing for bytes coming from a serial receiver.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one received byte per transfer together with the receiver's
//   framing and overrun flags. o_out carries results: echo bytes, delivered
//   line bytes, bell, end of file, error and interrupt; last marks the final
//   result caused by one received byte. Bytes that cause no result (ignored
//   control bytes, erase on an empty line) are taken and dropped.
//   The first result of a byte passes through the command queue and then
//   the result register. Single-result bytes flow at one per cycle while
//   the back end is idle and o_out does not stall. Reprint and newline read
//   and then send each stored byte, and every erased byte takes three
//   results plus one look-up, as the line store has a single read port; a
//   kill-word first looks at the last stored byte.
//   A two-entry command queue lets the receiver side keep transferring while
//   the output side replays a long sequence; i_in.ready drops only when that
//   queue is full. When the receiver of o_out stalls, the result register
//   holds and the sequencer waits. Reset empties the line and the queue and
//   clears the output valid flag; the line store itself needs no clearing.
// ----------------------------------------------------------------------------
module serial_line_editor #(
    parameter int LINE_CAPACITY = sle_pkg::LINE_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sle_in_if.sink     i_in,
    sle_out_if.source  o_out
);
    import sle_pkg::*;

    // Classified commands travel from the front end through the queue.
    logic      w_push;
    t_cmd_item w_push_item;
    logic      w_q_full;
    logic      w_q_valid;
    t_cmd_item w_q_item;
    logic      w_q_pop;

    sle_front u_front (
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_item   (w_push_item)
    );

    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // The back end owns the line store and sequences every multi-result reply.
    sle_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_out     (o_out)
    );

    // Status results carry no byte.
    a_status_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_BELL || o_out.kind == KIND_EOF ||
         o_out.kind == KIND_ERR || o_out.kind == KIND_INTR))
        |-> (o_out.out_byte == '0))
    else $error("status result with nonzero byte");

    // Status results always end their reply.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.kind == KIND_BELL || o_out.kind == KIND_EOF ||
         o_out.kind == KIND_ERR || o_out.kind == KIND_INTR))
        |-> o_out.last)
    else $error("status result not marked last");

    // A delivered line always ends in LF.
    a_line_ends_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_LINE && o_out.last)
        |-> (o_out.out_byte == CH_LF))
    else $error("delivered line does not end in LF");

    // The front end never pushes into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_full |-> !w_push)
    else $error("push into full command queue");

endmodule
